// ===== src/config_text_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// config_text_tokenizer_top_macros
// assertion macros used by the tokenizer checker
// ----------------------------------------------------------------------------
`ifndef CONFIG_TEXT_TOKENIZER_TOP_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CTT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// next-cycle implication, disabled while reset is asserted
`define CTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// ===== src/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// shared types, codes and character helpers for the config text tokenizer
// ----------------------------------------------------------------------------
package ctt_pkg;

	localparam int unsigned POS_BITS_DEF = 16;

	// token kinds
	localparam logic [3:0] KIND_LBRACE = 4'd0;
	localparam logic [3:0] KIND_RBRACE = 4'd1;
	localparam logic [3:0] KIND_COLON  = 4'd2;
	localparam logic [3:0] KIND_COMMA  = 4'd3;
	localparam logic [3:0] KIND_BANG   = 4'd4;
	localparam logic [3:0] KIND_STRING = 4'd5;
	localparam logic [3:0] KIND_NAME   = 4'd6;
	localparam logic [3:0] KIND_END    = 4'd7;
	localparam logic [3:0] KIND_ERROR  = 4'd8;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_ESC_AT_END = 2'd1;
	localparam logic [1:0] ERR_OPEN_STR   = 2'd2;
	localparam logic [1:0] ERR_BAD_CHAR   = 2'd3;

	// characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_UP_U   = 8'h55;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic        char_valid;
		logic [7:0]  value_char;
		logic        token_done;
		logic [15:0] token_line;
		logic [15:0] start_column;
		logic [1:0]  error_code;
		logic        last;
	} result_t;

	// what the scanner makes of one request
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} scan_out_t;

	function automatic result_t make_result(
		input logic [3:0]  kind,
		input logic        cv,
		input logic [7:0]  ch,
		input logic        done,
		input logic [15:0] line,
		input logic [15:0] col,
		input logic [1:0]  err
	);
		result_t r;
		r.token_kind   = kind;
		r.char_valid   = cv;
		r.value_char   = cv ? ch : 8'h00;
		r.token_done   = done;
		r.token_line   = line;
		r.start_column = col;
		r.error_code   = err;
		r.last         = 1'b0;
		return r;
	endfunction

	function automatic logic name_lead_ok(input logic [7:0] c);
		return (c == CH_UNDER) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic name_body_ok(input logic [7:0] c);
		return name_lead_ok(c) || (c == CH_DASH) || (c == CH_DOT) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

// ===== src/config_text_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// config_text_tokenizer_top
// streaming tokenizer for a small configuration text language
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  byte    | byte_valid, byte_stall | action, text_byte
//  tok     | tok_valid, tok_stall   | token_kind, char_valid, value_char,
//          |                        | token_done, token_line, start_column,
//          |                        | error_code, last
//
//  one request per clock while byte_stall is low; a request is registered in
//  the input register, scanned, and its first result registered in the output
//  register, which drives the outputs.
//  a request giving two results holds the input side while the second result
//  waits in the pending register behind the output.
//  arst_n clears scanner state and all valid flags.
//  tok_stall holds the output and the pending register, then backs up byte_stall.
// ----------------------------------------------------------------------------
module config_text_tokenizer_top #(
	parameter int unsigned POS_BITS = ctt_pkg::POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic        action,
	input  logic [7:0]  text_byte,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [3:0]  token_kind,
	output logic        char_valid,
	output logic [7:0]  value_char,
	output logic        token_done,
	output logic [15:0] token_line,
	output logic [15:0] start_column,
	output logic [1:0]  error_code,
	output logic        last
);

	logic               valid_s1;
	logic               action_s1;
	logic [7:0]         byte_s1;
	logic               out_valid_q;
	ctt_pkg::result_t   out_q;
	logic               pend_valid_q;
	ctt_pkg::result_t   pend_q;
	logic               out_free;
	logic               step;
	ctt_pkg::scan_out_t scan;

	assign out_free   = !out_valid_q || !tok_stall;
	assign step       = valid_s1 && !pend_valid_q && out_free;
	assign byte_stall = valid_s1 && !step;

	ctt_scan #(
		.POS_BITS (POS_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.action    (action_s1),
		.text_byte (byte_s1),
		.scan      (scan)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			action_s1 <= action;
			byte_s1   <= text_byte;
		end
	end

	// output register and pending second result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q && out_free) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q  <= (scan.count != 2'd0);
			pend_valid_q <= (scan.count == 2'd2);
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end else if (step) begin
			out_q  <= scan.first;
			pend_q <= scan.second;
		end
	end

	assign tok_valid    = out_valid_q;
	assign token_kind   = out_q.token_kind;
	assign char_valid   = out_q.char_valid;
	assign value_char   = out_q.value_char;
	assign token_done   = out_q.token_done;
	assign token_line   = out_q.token_line;
	assign start_column = out_q.start_column;
	assign error_code   = out_q.error_code;
	assign last         = out_q.last;

endmodule

// ===== src/ctt_scan.sv =====
// ----------------------------------------------------------------------------
// ctt_scan
// scanner state and next-state logic: one request in, up to two results out
// ----------------------------------------------------------------------------
module ctt_scan #(
	parameter int unsigned POS_BITS = ctt_pkg::POS_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                action,
	input  logic [7:0]          text_byte,
	output ctt_pkg::scan_out_t  scan
);

	typedef enum logic [5:0] {
		MODE_IDLE = 6'b000001,
		MODE_NAME = 6'b000010,
		MODE_STR  = 6'b000100,
		MODE_ESC  = 6'b001000,
		MODE_HEX  = 6'b010000,
		MODE_ERR  = 6'b100000
	} mode_t;

	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

	mode_t               mode_q, mode_d;
	logic [3:0]          hex_left_q, hex_left_d;
	logic [POS_BITS-1:0] cur_line_q, cur_line_d;
	logic [POS_BITS-1:0] cur_column_q, cur_column_d;
	logic [POS_BITS-1:0] tok_line_q, tok_line_d;
	logic [POS_BITS-1:0] tok_column_q, tok_column_d;

	logic                idle_has;
	logic                idle_ws;
	mode_t               idle_mode;
	ctt_pkg::result_t    idle_res;
	ctt_pkg::result_t    r0, r1;
	logic [1:0]          count;

	function automatic logic [15:0] lo16(input logic [POS_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[15:0];
	endfunction

	logic [15:0] cur_line16, cur_col16, tok_line16, tok_col16;
	assign cur_line16 = lo16(cur_line_q);
	assign cur_col16  = lo16(cur_column_q);
	assign tok_line16 = lo16(tok_line_q);
	assign tok_col16  = lo16(tok_column_q);

	// a byte seen while idle, between tokens
	always_comb begin
		idle_ws   = text_byte inside {ctt_pkg::CH_SPACE, ctt_pkg::CH_TAB,
			ctt_pkg::CH_CR, ctt_pkg::CH_LF};
		idle_has  = !idle_ws;
		idle_mode = MODE_IDLE;
		idle_res  = '0;
		case (text_byte)
			ctt_pkg::CH_LBRACE: idle_res = ctt_pkg::make_result(ctt_pkg::KIND_LBRACE,
				1'b1, text_byte, 1'b1, cur_line16, cur_col16, ctt_pkg::ERR_NONE);
			ctt_pkg::CH_RBRACE: idle_res = ctt_pkg::make_result(ctt_pkg::KIND_RBRACE,
				1'b1, text_byte, 1'b1, cur_line16, cur_col16, ctt_pkg::ERR_NONE);
			ctt_pkg::CH_COLON: idle_res = ctt_pkg::make_result(ctt_pkg::KIND_COLON,
				1'b1, text_byte, 1'b1, cur_line16, cur_col16, ctt_pkg::ERR_NONE);
			ctt_pkg::CH_COMMA: idle_res = ctt_pkg::make_result(ctt_pkg::KIND_COMMA,
				1'b1, text_byte, 1'b1, cur_line16, cur_col16, ctt_pkg::ERR_NONE);
			ctt_pkg::CH_BANG: idle_res = ctt_pkg::make_result(ctt_pkg::KIND_BANG,
				1'b1, text_byte, 1'b1, cur_line16, cur_col16, ctt_pkg::ERR_NONE);
			ctt_pkg::CH_QUOTE: begin
				idle_has  = 1'b0;
				idle_mode = MODE_STR;
			end
			default: begin
				if (idle_ws) begin
					idle_has = 1'b0;
				end else if (ctt_pkg::name_lead_ok(text_byte)) begin
					idle_mode = MODE_NAME;
					idle_res  = ctt_pkg::make_result(ctt_pkg::KIND_NAME, 1'b1, text_byte,
						1'b0, cur_line16, cur_col16, ctt_pkg::ERR_NONE);
				end else begin
					idle_mode = MODE_ERR;
					idle_res  = ctt_pkg::make_result(ctt_pkg::KIND_ERROR, 1'b0, 8'h00,
						1'b1, cur_line16, cur_col16, ctt_pkg::ERR_BAD_CHAR);
				end
			end
		endcase
	end

	always_comb begin
		mode_d       = mode_q;
		hex_left_d   = hex_left_q;
		cur_line_d   = cur_line_q;
		cur_column_d = cur_column_q;
		tok_line_d   = tok_line_q;
		tok_column_d = tok_column_q;
		r0           = '0;
		r1           = '0;
		count        = 2'd0;

		if (action) begin
			case (mode_q)
				MODE_IDLE: begin
					r0    = ctt_pkg::make_result(ctt_pkg::KIND_END, 1'b0, 8'h00, 1'b1,
						cur_line16, cur_col16, ctt_pkg::ERR_NONE);
					count = 2'd1;
				end
				MODE_NAME: begin
					r0    = ctt_pkg::make_result(ctt_pkg::KIND_NAME, 1'b0, 8'h00, 1'b1,
						tok_line16, tok_col16, ctt_pkg::ERR_NONE);
					r1    = ctt_pkg::make_result(ctt_pkg::KIND_END, 1'b0, 8'h00, 1'b1,
						cur_line16, cur_col16, ctt_pkg::ERR_NONE);
					count = 2'd2;
				end
				MODE_STR, MODE_HEX: begin
					r0    = ctt_pkg::make_result(ctt_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
						tok_line16, tok_col16, ctt_pkg::ERR_OPEN_STR);
					count = 2'd1;
				end
				MODE_ESC: begin
					r0    = ctt_pkg::make_result(ctt_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1,
						cur_line16, cur_col16, ctt_pkg::ERR_ESC_AT_END);
					count = 2'd1;
				end
				default: count = 2'd0;
			endcase
			// end of input re-arms everything
			mode_d       = MODE_IDLE;
			hex_left_d   = 4'd0;
			cur_line_d   = POS_ONE;
			cur_column_d = POS_ONE;
			tok_line_d   = POS_ONE;
			tok_column_d = POS_ONE;
		end else if (mode_q != MODE_ERR) begin
			case (mode_q)
				MODE_IDLE: begin
					r0     = idle_res;
					count  = {1'b0, idle_has};
					mode_d = idle_mode;
					if (!idle_ws) begin
						tok_line_d   = cur_line_q;
						tok_column_d = cur_column_q;
					end
				end
				MODE_NAME: begin
					if (ctt_pkg::name_body_ok(text_byte)) begin
						r0    = ctt_pkg::make_result(ctt_pkg::KIND_NAME, 1'b1, text_byte,
							1'b0, tok_line16, tok_col16, ctt_pkg::ERR_NONE);
						count = 2'd1;
					end else begin
						// close the name, then treat the byte as seen from idle
						r0     = ctt_pkg::make_result(ctt_pkg::KIND_NAME, 1'b0, 8'h00,
							1'b1, tok_line16, tok_col16, ctt_pkg::ERR_NONE);
						r1     = idle_res;
						count  = idle_has ? 2'd2 : 2'd1;
						mode_d = idle_mode;
						if (!idle_ws) begin
							tok_line_d   = cur_line_q;
							tok_column_d = cur_column_q;
						end
					end
				end
				MODE_STR: begin
					count = 2'd1;
					if (text_byte == ctt_pkg::CH_QUOTE) begin
						r0     = ctt_pkg::make_result(ctt_pkg::KIND_STRING, 1'b0, 8'h00,
							1'b1, tok_line16, tok_col16, ctt_pkg::ERR_NONE);
						mode_d = MODE_IDLE;
					end else begin
						r0 = ctt_pkg::make_result(ctt_pkg::KIND_STRING, 1'b1, text_byte,
							1'b0, tok_line16, tok_col16, ctt_pkg::ERR_NONE);
						if (text_byte == ctt_pkg::CH_BSLASH) begin
							mode_d = MODE_ESC;
						end
					end
				end
				MODE_ESC: begin
					count = 2'd1;
					r0    = ctt_pkg::make_result(ctt_pkg::KIND_STRING, 1'b1, text_byte,
						1'b0, tok_line16, tok_col16, ctt_pkg::ERR_NONE);
					case (text_byte)
						ctt_pkg::CH_LOW_X: begin
							hex_left_d = 4'd2;
							mode_d     = MODE_HEX;
						end
						ctt_pkg::CH_LOW_U: begin
							hex_left_d = 4'd4;
							mode_d     = MODE_HEX;
						end
						ctt_pkg::CH_UP_U: begin
							hex_left_d = 4'd8;
							mode_d     = MODE_HEX;
						end
						default: mode_d = MODE_STR;
					endcase
				end
				MODE_HEX: begin
					count = 2'd1;
					if (text_byte == ctt_pkg::CH_QUOTE) begin
						r0         = ctt_pkg::make_result(ctt_pkg::KIND_STRING, 1'b0, 8'h00,
							1'b1, tok_line16, tok_col16, ctt_pkg::ERR_NONE);
						hex_left_d = 4'd0;
						mode_d     = MODE_IDLE;
					end else begin
						r0         = ctt_pkg::make_result(ctt_pkg::KIND_STRING, 1'b1,
							text_byte, 1'b0, tok_line16, tok_col16, ctt_pkg::ERR_NONE);
						hex_left_d = hex_left_q - 4'd1;
						if (hex_left_q == 4'd1) begin
							mode_d = MODE_STR;
						end
					end
				end
				default: count = 2'd0;
			endcase

			// position tracking, saturating
			if (text_byte == ctt_pkg::CH_LF) begin
				if (!(&cur_line_q)) begin
					cur_line_d = cur_line_q + POS_ONE;
				end
				cur_column_d = POS_ONE;
			end else if (!(&cur_column_q)) begin
				cur_column_d = cur_column_q + POS_ONE;
			end
		end

		if (count == 2'd1) begin
			r0.last = 1'b1;
		end
		if (count == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	assign scan.count  = count;
	assign scan.first  = r0;
	assign scan.second = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			hex_left_q   <= 4'd0;
			cur_line_q   <= POS_ONE;
			cur_column_q <= POS_ONE;
			tok_line_q   <= POS_ONE;
			tok_column_q <= POS_ONE;
		end else if (step) begin
			mode_q       <= mode_d;
			hex_left_q   <= hex_left_d;
			cur_line_q   <= cur_line_d;
			cur_column_q <= cur_column_d;
			tok_line_q   <= tok_line_d;
			tok_column_q <= tok_column_d;
		end
	end

endmodule

// ===== src/ctt_checker.sv =====
// ----------------------------------------------------------------------------
// ctt_checker
// port-level checks on the tokenizer output, bound to the top level
// ----------------------------------------------------------------------------
`include "config_text_tokenizer_top_macros.svh"

module ctt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_stall,
	input logic [3:0]  token_kind,
	input logic        char_valid,
	input logic [7:0]  value_char,
	input logic        token_done,
	input logic [15:0] token_line,
	input logic [15:0] start_column,
	input logic [1:0]  error_code,
	input logic        last
);

	// a held result does not change
	`CTT_ASSERT_NEXT(a_hold, clk, arst_n, tok_valid && tok_stall, tok_valid && $stable(token_kind) && $stable(value_char) && $stable(last) && $stable(token_line))

	// no character means a zero character field
	`CTT_ASSERT_IMPLY(a_char_zero, clk, arst_n, tok_valid && !char_valid, value_char == 8'h00)

	// an error code only rides on a completed error token
	`CTT_ASSERT_IMPLY(a_err_kind, clk, arst_n, tok_valid && (error_code != ctt_pkg::ERR_NONE), (token_kind == ctt_pkg::KIND_ERROR) && token_done && !char_valid)

	// the end token closes its request and carries no character
	`CTT_ASSERT_IMPLY(a_end_last, clk, arst_n, tok_valid && (token_kind == ctt_pkg::KIND_END), token_done && last && !char_valid)

	// start positions of completed tokens are never zero
	`CTT_ASSERT_IMPLY(a_pos_nonzero, clk, arst_n, tok_valid && token_done, (token_line != 16'd0) && (start_column != 16'd0))

endmodule

bind config_text_tokenizer_top ctt_checker u_ctt_checker (.*);
